// File: rtl/fcc_pkg.sv
package fcc_pkg;

	// Default build values
	localparam int COORD_BITS_DEF   = 16;
	localparam int MAJOR_WEIGHT_DEF = 13;

	// Direction codes; anything above DIR_DOWN never gives a better candidate
	localparam int DIR_W = 3;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
	localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DIR   = 3'd4;

	// Per-rectangle relations to the source rectangle
	typedef struct packed {
		logic lies;    // both major-axis edges beyond the source's edges
		logic beam;    // overlaps the source on the minor axis
		logic beyond;  // near edge fully past the source's leading edge
	} geom_flags_t;

	// Load enables of the later pipeline stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// File: rtl/fcc_geom.sv
module fcc_geom import fcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic [DIR_W-1:0]             dir,
	input  logic signed [COORD_BITS-1:0] sl,
	input  logic signed [COORD_BITS-1:0] st,
	input  logic signed [COORD_BITS-1:0] sr,
	input  logic signed [COORD_BITS-1:0] sb,
	input  logic signed [COORD_BITS-1:0] xl,
	input  logic signed [COORD_BITS-1:0] xt,
	input  logic signed [COORD_BITS-1:0] xr,
	input  logic signed [COORD_BITS-1:0] xb,
	output geom_flags_t                  flags,
	output logic [COORD_BITS-1:0]        near_gap,
	output logic [COORD_BITS-1:0]        far_gap,
	output logic signed [COORD_BITS+1:0] mnr_diff
);

	localparam int W = COORD_BITS;

	logic signed [W:0]   near_d, far_d;
	logic signed [W+1:0] s_sum_h, x_sum_h, s_sum_v, x_sum_v;
	logic                horiz;

	// Doubled centers along each axis
	assign s_sum_h = (W+2)'(st) + (W+2)'(sb);
	assign x_sum_h = (W+2)'(xt) + (W+2)'(xb);
	assign s_sum_v = (W+2)'(sl) + (W+2)'(sr);
	assign x_sum_v = (W+2)'(xl) + (W+2)'(xr);

	assign horiz = (dir == DIR_LEFT) || (dir == DIR_RIGHT);

	// Direction-dependent relations and raw gaps
	always_comb begin
		case (dir)
			DIR_LEFT: begin
				flags.lies   = (sl > xl) && (sr > xr);
				flags.beyond = (sl >= xr);
				near_d       = (W+1)'(sl) - (W+1)'(xr);
				far_d        = (W+1)'(sl) - (W+1)'(xl);
			end
			DIR_RIGHT: begin
				flags.lies   = (sl < xl) && (sr < xr);
				flags.beyond = (sr <= xl);
				near_d       = (W+1)'(xl) - (W+1)'(sr);
				far_d        = (W+1)'(xr) - (W+1)'(sr);
			end
			DIR_UP: begin
				flags.lies   = (st > xt) && (sb > xb);
				flags.beyond = (st >= xb);
				near_d       = (W+1)'(st) - (W+1)'(xb);
				far_d        = (W+1)'(st) - (W+1)'(xt);
			end
			default: begin
				flags.lies   = (st < xt) && (sb < xb);
				flags.beyond = (sb <= xt);
				near_d       = (W+1)'(xt) - (W+1)'(sb);
				far_d        = (W+1)'(xb) - (W+1)'(sb);
			end
		endcase
		flags.beam = horiz ? ((st < xb) && (xt < sb)) : ((sl < xr) && (xl < sr));
	end

	// Near gap clamped at 0, far gap clamped at 1; both fit W unsigned bits
	assign near_gap = (near_d > 0) ? near_d[W-1:0] : '0;
	assign far_gap  = (far_d > 1) ? far_d[W-1:0] : W'(1);

	assign mnr_diff = horiz ? (s_sum_h - x_sum_h) : (s_sum_v - x_sum_v);

endmodule

// File: rtl/fcc_score.sv
module fcc_score import fcc_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int MAJOR_WEIGHT = MAJOR_WEIGHT_DEF
) (
	input  logic                         clk,
	input  stage_en_t                    en,
	input  logic [COORD_BITS-1:0]        maj,
	input  logic signed [COORD_BITS+1:0] mnr_diff,
	output logic [2*COORD_BITS+$clog2(4*MAJOR_WEIGHT+1):0] score
);

	localparam int W      = COORD_BITS;
	localparam int WT_W   = $clog2(4*MAJOR_WEIGHT+1);
	localparam int WMAJ_W = 2*W + WT_W;
	localparam int SC_W   = WMAJ_W + 1;
	localparam logic [WT_W-1:0] WT = WT_W'(4*MAJOR_WEIGHT);

	logic signed [W+1:0] mnr_neg;
	logic [W:0]          mnr_abs;
	logic [2*W-1:0]      maj_sq_s2;
	logic [2*W+1:0]      mnr_sq_s2, mnr_sq_s3;
	logic [WMAJ_W-1:0]   wmaj_s3;
	logic [SC_W-1:0]     score_s4;

	// Magnitude of the doubled minor offset
	assign mnr_neg = -mnr_diff;
	assign mnr_abs = mnr_diff[W+1] ? mnr_neg[W:0] : mnr_diff[W:0];

	// Stage 2: squares
	always_ff @(posedge clk) begin
		if (en.s2) begin
			maj_sq_s2 <= (2*W)'(maj) * (2*W)'(maj);
			mnr_sq_s2 <= (2*W+2)'(mnr_abs) * (2*W+2)'(mnr_abs);
		end
	end

	// Stage 3: weight the major term
	always_ff @(posedge clk) begin
		if (en.s3) begin
			wmaj_s3   <= WMAJ_W'(maj_sq_s2) * WMAJ_W'(WT);
			mnr_sq_s3 <= mnr_sq_s2;
		end
	end

	// Stage 4: weighted distance
	always_ff @(posedge clk) begin
		if (en.s4) begin
			score_s4 <= SC_W'(wmaj_s3) + SC_W'(mnr_sq_s3);
		end
	end

	assign score = score_s4;

endmodule

// File: rtl/focus_candidate_compare.sv
// Channel  Direction  Handshake                 Payload
// in       to block   in_valid / in_stall       cand_* and best_* edges
// out      from block out_valid / out_stall     is_better
// cfg      to block   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Five register stages: relations and gaps, squares and rule decision,
// weighting, distance sum, final compare. One word per cycle is sustained
// while out_stall stays low.
// Each stage advances when it is empty or the one after it advances, so
// bubbles close up while the output is stalled. cfg_ready is always high.
// Reset clears the source rectangle and direction and empties the pipeline.
module focus_candidate_compare import fcc_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int MAJOR_WEIGHT = MAJOR_WEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] cand_left,
	input  logic signed [COORD_BITS-1:0] cand_top,
	input  logic signed [COORD_BITS-1:0] cand_right,
	input  logic signed [COORD_BITS-1:0] cand_bottom,
	input  logic signed [COORD_BITS-1:0] best_left,
	input  logic signed [COORD_BITS-1:0] best_top,
	input  logic signed [COORD_BITS-1:0] best_right,
	input  logic signed [COORD_BITS-1:0] best_bottom,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         is_better,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data
);

	localparam int W    = COORD_BITS;
	localparam int SC_W = 2*W + $clog2(4*MAJOR_WEIGHT+1) + 1;

	logic signed [W-1:0] src_left_q, src_top_q, src_right_q, src_bottom_q;
	logic [DIR_W-1:0]    dir_q;

	geom_flags_t         flags_c, flags_b, flags_c_s1, flags_b_s1;
	logic [W-1:0]        near_c, near_b, far_c, far_b;
	logic [W-1:0]        near_c_s1, near_b_s1, far_c_s1, far_b_s1;
	logic signed [W+1:0] mnr_c, mnr_b, mnr_c_s1, mnr_b_s1;
	logic [SC_W-1:0]     score_c, score_b;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic known_s2, known_s3, known_s4;
	logic val_s2, val_s3, val_s4;
	logic is_better_s5;
	logic dir_ok, horiz, beats_cb, beats_bc, known_d, val_d;
	stage_en_t en;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_left_q   <= '0;
			src_top_q    <= '0;
			src_right_q  <= '0;
			src_bottom_q <= '0;
			dir_q        <= DIR_LEFT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC_LEFT:   src_left_q   <= cfg_data;
				CFG_SRC_TOP:    src_top_q    <= cfg_data;
				CFG_SRC_RIGHT:  src_right_q  <= cfg_data;
				CFG_SRC_BOTTOM: src_bottom_q <= cfg_data;
				CFG_MOVE_DIR:   dir_q        <= cfg_data[DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: a stage loads when empty or when its successor moves on
	assign rdy_s5   = !valid_s5 || !out_stall;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign out_valid = valid_s5;

	assign en.s2 = rdy_s2;
	assign en.s3 = rdy_s3;
	assign en.s4 = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= valid_s4;
		end
	end

	// Geometry of each rectangle against the source
	fcc_geom #(.COORD_BITS(COORD_BITS)) u_geom_c (
		.dir(dir_q), .sl(src_left_q), .st(src_top_q), .sr(src_right_q), .sb(src_bottom_q),
		.xl(cand_left), .xt(cand_top), .xr(cand_right), .xb(cand_bottom),
		.flags(flags_c), .near_gap(near_c), .far_gap(far_c), .mnr_diff(mnr_c)
	);

	fcc_geom #(.COORD_BITS(COORD_BITS)) u_geom_b (
		.dir(dir_q), .sl(src_left_q), .st(src_top_q), .sr(src_right_q), .sb(src_bottom_q),
		.xl(best_left), .xt(best_top), .xr(best_right), .xb(best_bottom),
		.flags(flags_b), .near_gap(near_b), .far_gap(far_b), .mnr_diff(mnr_b)
	);

	// Stage 1 registers
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			flags_c_s1 <= flags_c;
			flags_b_s1 <= flags_b;
			near_c_s1  <= near_c;
			near_b_s1  <= near_b;
			far_c_s1   <= far_c;
			far_b_s1   <= far_b;
			mnr_c_s1   <= mnr_c;
			mnr_b_s1   <= mnr_b;
		end
	end

	// Rule decision: direction, placement, then beam overlap
	assign dir_ok = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT) ||
	                (dir_q == DIR_UP) || (dir_q == DIR_DOWN);
	assign horiz  = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT);

	assign beats_cb = !flags_b_s1.beam && flags_c_s1.beam &&
	                  (!flags_b_s1.beyond || horiz || (near_c_s1 < far_b_s1));
	assign beats_bc = !flags_c_s1.beam && flags_b_s1.beam &&
	                  (!flags_c_s1.beyond || horiz || (near_b_s1 < far_c_s1));

	always_comb begin
		known_d = 1'b1;
		val_d   = 1'b0;
		if (!dir_ok || !flags_c_s1.lies) begin
			val_d = 1'b0;
		end else if (!flags_b_s1.lies || beats_cb) begin
			val_d = 1'b1;
		end else if (beats_bc) begin
			val_d = 1'b0;
		end else begin
			known_d = 1'b0;
		end
	end

	// Distance scores for the tie-break
	fcc_score #(.COORD_BITS(COORD_BITS), .MAJOR_WEIGHT(MAJOR_WEIGHT)) u_score_c (
		.clk(clk), .en(en), .maj(near_c_s1), .mnr_diff(mnr_c_s1), .score(score_c)
	);

	fcc_score #(.COORD_BITS(COORD_BITS), .MAJOR_WEIGHT(MAJOR_WEIGHT)) u_score_b (
		.clk(clk), .en(en), .maj(near_b_s1), .mnr_diff(mnr_b_s1), .score(score_b)
	);

	// Decision travels alongside the scores
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			known_s2 <= known_d;
			val_s2   <= val_d;
		end
		if (rdy_s3) begin
			known_s3 <= known_s2;
			val_s3   <= val_s2;
		end
		if (rdy_s4) begin
			known_s4 <= known_s3;
			val_s4   <= val_s3;
		end
		if (rdy_s5) begin
			is_better_s5 <= known_s4 ? val_s4 : (score_c < score_b);
		end
	end

	assign is_better = is_better_s5;

endmodule

// File: tb/fcc_compare_monitor.sv
// Watches the configuration, candidate and result channels of the focus
// compare block, predicts is_better for every accepted candidate word and
// checks each result word against the oldest prediction.
module fcc_compare_monitor import fcc_pkg::*; #(
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int MAJOR_WEIGHT = MAJOR_WEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] cand_left,
	input  logic signed [COORD_BITS-1:0] cand_top,
	input  logic signed [COORD_BITS-1:0] cand_right,
	input  logic signed [COORD_BITS-1:0] cand_bottom,
	input  logic signed [COORD_BITS-1:0] best_left,
	input  logic signed [COORD_BITS-1:0] best_top,
	input  logic signed [COORD_BITS-1:0] best_right,
	input  logic signed [COORD_BITS-1:0] best_bottom,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         is_better,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	output int                           fail_count,
	output int                           outstanding,
	output int                           checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		longint l;
		longint t;
		longint r;
		longint b;
	} rect_t;

	// shadow copy of the source rectangle and direction
	logic [COORD_BITS-1:0] src_q [4];
	logic [DIR_W-1:0]      dir_q;

	// predicted is_better words, oldest first
	bit    verdict_q [$];
	rect_t src_r, cand_r, best_r;
	bit    want;
	int    delta;

	function automatic longint sx(logic [COORD_BITS-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic bit horiz(logic [DIR_W-1:0] d);
		return d == DIR_LEFT || d == DIR_RIGHT;
	endfunction

	// overlap with the source on the minor axis, strict on both edges
	function automatic bit beam_hit(rect_t s, rect_t x, logic [DIR_W-1:0] d);
		if (horiz(d))
			return s.t < x.b && x.t < s.b;
		return s.l < x.r && x.l < s.r;
	endfunction

	// near edge fully past the source's leading edge
	function automatic bit past_edge(rect_t s, rect_t x, logic [DIR_W-1:0] d);
		case (d)
			DIR_LEFT:  return s.l >= x.r;
			DIR_RIGHT: return s.r <= x.l;
			DIR_UP:    return s.t >= x.b;
			default:   return s.b <= x.t;
		endcase
	endfunction

	// both major-axis edges beyond the source's matching edges
	function automatic bit heads_toward(rect_t s, rect_t x, logic [DIR_W-1:0] d);
		case (d)
			DIR_LEFT:  return s.l > x.l && s.r > x.r;
			DIR_RIGHT: return s.l < x.l && s.r < x.r;
			DIR_UP:    return s.t > x.t && s.b > x.b;
			default:   return s.t < x.t && s.b < x.b;
		endcase
	endfunction

	function automatic longint lead_gap(rect_t s, rect_t x, logic [DIR_W-1:0] d);
		longint g;
		case (d)
			DIR_LEFT:  g = s.l - x.r;
			DIR_RIGHT: g = x.l - s.r;
			DIR_UP:    g = s.t - x.b;
			default:   g = x.t - s.b;
		endcase
		return g > 0 ? g : 0;
	endfunction

	function automatic longint trail_gap(rect_t s, rect_t x, logic [DIR_W-1:0] d);
		longint g;
		case (d)
			DIR_LEFT:  g = s.l - x.l;
			DIR_RIGHT: g = x.r - s.r;
			DIR_UP:    g = s.t - x.t;
			default:   g = x.b - s.b;
		endcase
		return g > 1 ? g : 1;
	endfunction

	// beam rule: a wins outright over b
	function automatic bit outranks(rect_t s, logic [DIR_W-1:0] d, rect_t a, rect_t b);
		if (beam_hit(s, b, d) || !beam_hit(s, a, d))
			return 1'b0;
		if (!past_edge(s, b, d))
			return 1'b1;
		if (horiz(d))
			return 1'b1;
		return lead_gap(s, a, d) < trail_gap(s, b, d);
	endfunction

	// 4*W*major^2 + (doubled minor)^2, exact
	function automatic logic [127:0] weighted_dist(rect_t s, rect_t x, logic [DIR_W-1:0] d);
		longint maj, diff;
		maj = lead_gap(s, x, d);
		if (horiz(d))
			diff = (s.t + s.b) - (x.t + x.b);
		else
			diff = (s.l + s.r) - (x.l + x.r);
		if (diff < 0)
			diff = -diff;
		return 128'(maj) * 128'(4 * MAJOR_WEIGHT) * 128'(maj) + 128'(diff) * 128'(diff);
	endfunction

	function automatic bit judge_candidate(rect_t s, rect_t c, rect_t b, logic [DIR_W-1:0] d);
		if (d > DIR_DOWN || !heads_toward(s, c, d))
			return 1'b0;
		if (!heads_toward(s, b, d))
			return 1'b1;
		if (outranks(s, d, c, b))
			return 1'b1;
		if (outranks(s, d, b, c))
			return 1'b0;
		return weighted_dist(s, c, d) < weighted_dist(s, b, d);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				src_q[i] <= '0;
			dir_q       <= '0;
			fail_count  <= 0;
			outstanding <= 0;
			checked     <= 0;
			verdict_q.delete();
		end else begin
			delta = 0;

			// register writes; indexes past the direction are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SRC_LEFT, CFG_SRC_TOP, CFG_SRC_RIGHT, CFG_SRC_BOTTOM:
						src_q[cfg_index[1:0]] <= cfg_data;
					CFG_MOVE_DIR:
						dir_q <= cfg_data[DIR_W-1:0];
					default: ;
				endcase
			end

			// result word against the oldest prediction
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("is_better word with no candidate waiting: actual %0b", is_better);
					fail_count <= fail_count + 1;
				end else begin
					want = verdict_q.pop_front();
					delta--;
					checked <= checked + 1;
					if (is_better !== want) begin
						$error("is_better mismatch: expected %0b, actual %0b", want, is_better);
						fail_count <= fail_count + 1;
					end
				end
			end

			// candidate word accepted: predict its verdict
			if (in_valid && !in_stall) begin
				src_r  = '{sx(src_q[CFG_SRC_LEFT]), sx(src_q[CFG_SRC_TOP]),
					sx(src_q[CFG_SRC_RIGHT]), sx(src_q[CFG_SRC_BOTTOM])};
				cand_r = '{sx(cand_left), sx(cand_top), sx(cand_right), sx(cand_bottom)};
				best_r = '{sx(best_left), sx(best_top), sx(best_right), sx(best_bottom)};
				verdict_q.push_back(judge_candidate(src_r, cand_r, best_r, dir_q));
				delta++;
			end

			outstanding <= outstanding + delta;
		end
	end

endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the focus compare block; prediction and
// checking live in fcc_compare_monitor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fcc_pkg::*;

	localparam int CW            = COORD_BITS_DEF;
	localparam int CMAX          = (1 <<< (CW - 1)) - 1;
	localparam int CMIN          = -(1 <<< (CW - 1));
	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 10;
	localparam int PHASES        = 16;
	localparam int PHASE_WORDS   = 83;

	typedef struct packed {
		int l;
		int t;
		int r;
		int b;
	} box_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic signed [CW-1:0] cand_left   = '0;
	logic signed [CW-1:0] cand_top    = '0;
	logic signed [CW-1:0] cand_right  = '0;
	logic signed [CW-1:0] cand_bottom = '0;
	logic signed [CW-1:0] best_left   = '0;
	logic signed [CW-1:0] best_top    = '0;
	logic signed [CW-1:0] best_right  = '0;
	logic signed [CW-1:0] best_bottom = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 is_better;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CW-1:0]        cfg_data    = '0;

	int fail_count, outstanding, checked;

	// stimulus state
	bit   tx_idle = 1'b1;
	bit   rx_idle = 1'b1;
	box_t src;
	int   dir_set;
	int   words_sent = 0;
	int   settings   = 0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	int   rx_draw;

	focus_candidate_compare dut (.*);

	fcc_compare_monitor mon (.*);

	always #10 clk = ~clk;

	// result side: random stall after each accepted word when rx_idle is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			rx_draw = rx_idle ? $urandom_range(0, 14) : 0;
			stall_left <= rx_draw;
			out_stall  <= (rx_draw != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end
	end

	// watchdog: no handshake on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$error("no handshake for %0d cycles", idle_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [CW-1:0] sat(int v);
		if (v > CMAX)
			v = CMAX;
		if (v < CMIN)
			v = CMIN;
		return CW'(v);
	endfunction

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// major-axis step away from the source
	function automatic int reach();
		return (rnd(0, 3) == 0) ? rnd(1, 8) : rnd(1, 160);
	endfunction

	// map a box drawn for the right direction onto direction d
	// (valid for a source centered on the origin)
	function automatic box_t orient(box_t x, int d);
		case (d)
			DIR_LEFT: return '{-x.r, x.t, -x.l, x.b};
			DIR_UP:   return '{x.t, -x.r, x.b, -x.l};
			DIR_DOWN: return '{x.t, x.l, x.b, x.r};
			default:  return x;
		endcase
	endfunction

	// box lying in direction d from the current source
	function automatic box_t gen_toward(int d);
		box_t x;
		int lo, hi, m0, m1;
		if (d == DIR_LEFT || d == DIR_RIGHT) begin
			lo = src.t;
			hi = src.b;
		end else begin
			lo = src.l;
			hi = src.r;
		end
		if (lo > hi) begin
			m0 = lo;
			lo = hi;
			hi = m0;
		end
		m0 = rnd(lo - 80, hi + 40);
		m1 = m0 + rnd(0, 60);
		case (d)
			DIR_LEFT:  x = '{src.l - reach(), m0, src.r - reach(), m1};
			DIR_RIGHT: x = '{src.l + reach(), m0, src.r + reach(), m1};
			DIR_UP:    x = '{m0, src.t - reach(), m1, src.b - reach()};
			default:   x = '{m0, src.t + reach(), m1, src.b + reach()};
		endcase
		return x;
	endfunction

	// box somewhere around the source, sometimes inverted
	function automatic box_t gen_near();
		box_t x;
		int xl, xh, yl, yh, tmp;
		xl = (src.l < src.r) ? src.l : src.r;
		xh = (src.l < src.r) ? src.r : src.l;
		yl = (src.t < src.b) ? src.t : src.b;
		yh = (src.t < src.b) ? src.b : src.t;
		x.l = rnd(xl - 150, xh + 150);
		x.r = x.l + rnd(0, 80);
		x.t = rnd(yl - 150, yh + 150);
		x.b = x.t + rnd(0, 80);
		if (rnd(0, 9) == 0) begin
			tmp = x.l;
			x.l = x.r;
			x.r = tmp;
		end
		if (rnd(0, 9) == 0) begin
			tmp = x.t;
			x.t = x.b;
			x.b = tmp;
		end
		return x;
	endfunction

	function automatic box_t gen_noise();
		box_t x;
		x.l = int'($signed(CW'($urandom())));
		x.t = int'($signed(CW'($urandom())));
		x.r = int'($signed(CW'($urandom())));
		x.b = int'($signed(CW'($urandom())));
		return x;
	endfunction

	// one candidate word; valid stays high across back-to-back words
	task automatic push_word(box_t c, box_t b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand_left   <= sat(c.l);
		cand_top    <= sat(c.t);
		cand_right  <= sat(c.r);
		cand_bottom <= sat(c.b);
		best_left   <= sat(b.l);
		best_top    <= sat(b.t);
		best_right  <= sat(b.r);
		best_bottom <= sat(b.b);
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// write all registers; upper direction bits and stray indexes are junk
	task automatic load_source(box_t s, int d);
		logic [CW-1:0] dword;
		src.l   = int'($signed(sat(s.l)));
		src.t   = int'($signed(sat(s.t)));
		src.r   = int'($signed(sat(s.r)));
		src.b   = int'($signed(sat(s.b)));
		dir_set = d;
		dword   = CW'($urandom());
		dword[DIR_W-1:0] = DIR_W'(d);
		cfg_write(CFG_SRC_LEFT, sat(src.l));
		cfg_write(CFG_SRC_TOP, sat(src.t));
		cfg_write(CFG_SRC_RIGHT, sat(src.r));
		cfg_write(CFG_SRC_BOTTOM, sat(src.b));
		cfg_write(CFG_MOVE_DIR, dword);
		if (rnd(0, 2) == 0)
			cfg_write(CFG_MOVE_DIR + CFG_IDX_W'(rnd(1, 3)), CW'($urandom()));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// hold off until every predicted word has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		box_t sym, c, b;
		int gd, sel, tmp;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rules in every direction around a centered source, two only for down
		sym = '{-10, -10, 10, 10};
		for (int d = 0; d <= DIR_DOWN; d++) begin
			load_source(sym, d);
			// beam rule: candidate in beam, best not
			push_word(orient('{20, -5, 30, 5}, d), orient('{15, 20, 25, 30}, d));
			// identical rectangles tie
			push_word(orient('{20, -5, 30, 5}, d), orient('{20, -5, 30, 5}, d));
			// candidate not in the direction
			push_word(orient('{-20, -5, 5, 5}, d), orient('{20, -5, 30, 5}, d));
			// weighted distance decides
			push_word(orient('{12, 20, 14, 22}, d), orient('{40, 11, 42, 13}, d));
			// best out of beam and overlapping the source on the major axis
			push_word(orient('{20, -5, 30, 5}, d), orient('{5, 20, 30, 30}, d));
			if (d == DIR_DOWN) begin
				// minor edge touching the source edge is outside the beam
				push_word(orient('{20, 10, 30, 20}, d), orient('{40, 20, 50, 30}, d));
				// best not in the direction loses
				push_word(orient('{20, -5, 30, 5}, d), orient('{-5, -5, 5, 5}, d));
			end
			settle();
		end
		// two unused direction codes above DIR_DOWN
		load_source(sym, 4);
		push_word('{20, -5, 30, 5}, '{-5, -5, 5, 5});
		settle();
		load_source(sym, 7);
		push_word('{20, -5, 30, 5}, '{-5, -5, 5, 5});
		settle();
		// coordinate extremes
		load_source('{CMAX, CMAX, CMAX, CMAX}, DIR_LEFT);
		push_word('{CMIN, CMIN, CMIN, CMIN}, '{CMIN, CMIN, CMAX - 1, CMIN});
		settle();
		load_source('{CMIN, CMIN, CMIN, CMIN}, DIR_DOWN);
		push_word('{CMAX, CMAX, CMAX, CMAX}, '{CMAX, CMIN + 1, CMAX, CMAX});
		settle();

		// random phases, each with its own source, direction and idling mode
		for (int p = 0; p < PHASES; p++) begin
			tx_idle = (p % 4 == 0) || (p % 4 == 2);
			rx_idle = (p % 4 == 0) || (p % 4 == 3);
			sel = (p == 1) ? 1 : (p == 2) ? 0 : rnd(0, 7);
			if (sel == 0) begin
				sym = gen_noise();
			end else if (sel == 1) begin
				sym.l = (rnd(0, 1) == 1) ? CMIN : CMAX;
				sym.t = (rnd(0, 1) == 1) ? CMIN : CMAX;
				sym.r = (rnd(0, 2) == 0) ? CMIN : CMAX;
				sym.b = (rnd(0, 2) == 0) ? CMIN : CMAX;
			end else begin
				sym.l = rnd(-300, 300);
				sym.r = sym.l + rnd(0, 60);
				sym.t = rnd(-300, 300);
				sym.b = sym.t + rnd(0, 60);
				if (sel == 2) begin
					tmp   = sym.l;
					sym.l = sym.r;
					sym.r = tmp;
				end
			end
			load_source(sym, (p % 5 == 4) ? rnd(4, 7) : p % 4);

			for (int i = 0; i < PHASE_WORDS; i++) begin
				gd  = (dir_set <= DIR_DOWN) ? dir_set : rnd(0, 3);
				sel = rnd(0, 19);
				c   = gen_toward(gd);
				if (sel <= 13) begin
					b = gen_toward(gd);
				end else if (sel == 14) begin
					b = c;
				end else if (sel == 15) begin
					// mirror about the source center on the minor axis
					b = c;
					if (gd == DIR_LEFT || gd == DIR_RIGHT) begin
						b.t = (src.t + src.b) - c.b;
						b.b = (src.t + src.b) - c.t;
					end else begin
						b.l = (src.l + src.r) - c.r;
						b.r = (src.l + src.r) - c.l;
					end
				end else if (sel <= 17) begin
					b = gen_near();
				end else if (sel == 18) begin
					c = gen_near();
					b = gen_near();
				end else begin
					c = gen_noise();
					b = gen_noise();
				end
				push_word(c, b);
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d is_better words for %0d candidate words over %0d register settings.",
			checked, words_sent, settings);
		$display("Covered all four directions, forward and unused codes, extreme, inverted and",
			" random sources, with random gaps and stalls on both channels.");
		if (outstanding != 0)
			$error("%0d predicted is_better words never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
